[hdl/sjb_pkg.sv]
// ----------------------------------------------------------------------------
// Sequence jitter buffer package
// Shared widths, request and status codes, and the flag bundle.
// ----------------------------------------------------------------------------
package sjb_pkg;

   localparam int SEQ_W        = 16;
   localparam int THR_W        = 6;
   localparam int STATUS_W     = 3;
   localparam int DEF_DEPTH    = 32;
   localparam int DEF_DATA_W   = 32;

   localparam logic REQ_PUSH = 1'b0;
   localparam logic REQ_POP  = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      PUSH_OK    = 3'd0,
      PUSH_LATE  = 3'd1,
      PUSH_EARLY = 3'd2,
      PUSH_DUP   = 3'd3,
      PUSH_NONE  = 3'd4
   } push_status_type;

   typedef struct packed {
      logic front_valid;
      logic empty;
   } flags_type;

endpackage

[hdl/sequence_jitter_buffer.sv]
// ----------------------------------------------------------------------------
// Sequence jitter buffer
// A request beat passes through the input register, then one execute step
// that updates state and loads the response.
// Throughput: one beat per cycle unless rsp_ready stalls it, set by the single-step valid bit update.
// Reset clears valid bits, base, front, count, threshold and stage valids.
// ----------------------------------------------------------------------------
module sequence_jitter_buffer #(
   parameter int DEPTH      = sjb_pkg::DEF_DEPTH,
   parameter int DATA_WIDTH = sjb_pkg::DEF_DATA_W
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_type,
   input  logic [sjb_pkg::SEQ_W-1:0]        req_seq_number,
   input  logic [DATA_WIDTH-1:0]            req_payload,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [sjb_pkg::STATUS_W-1:0]     rsp_push_status,
   output logic                             rsp_front_valid,
   output logic [DATA_WIDTH-1:0]            rsp_front_data,
   output logic                             rsp_ready_flag,
   output logic                             rsp_empty_flag,
   input  logic                             csr_wr_en,
   input  logic [sjb_pkg::THR_W-1:0]        csr_wr_data
);
   import sjb_pkg::*;

   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic                  req_valid_ff;
   logic                  req_type_ff;
   logic [SEQ_W-1:0]      req_seq_ff;
   logic [DATA_WIDTH-1:0] req_payload_ff;
   logic                  rsp_valid_ff;
   push_status_type       status_ff;
   push_status_type       status_in;
   logic [THR_W-1:0]      threshold_ff;

   logic                  exec;
   logic                  wr_en;
   logic [IW-1:0]         wr_addr;
   logic [IW-1:0]         rd_addr;
   logic [DEPTH-1:0]      slot_valid;
   logic [IW-1:0]         front;
   flags_type             flags;
   logic [DATA_WIDTH-1:0] rd_data;
   logic                  ready_flag;

   assign exec      = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || exec;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         threshold_ff <= '0;
      end else begin
         if (req_ready) begin
            req_valid_ff <= req_valid;
         end
         if (exec) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_wr_en) begin
            threshold_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_type_ff    <= req_type;
         req_seq_ff     <= req_seq_number;
         req_payload_ff <= req_payload;
      end
      if (exec) begin
         status_ff <= status_in;
      end
   end

   sjb_ctrl #(
      .DEPTH (DEPTH),
      .IW    (IW)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .exec       (exec),
      .op         (req_type_ff),
      .seq        (req_seq_ff),
      .status     (status_in),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .rd_addr    (rd_addr),
      .slot_valid (slot_valid),
      .front      (front),
      .flags      (flags)
   );

   sjb_store #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH),
      .IW         (IW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_payload_ff),
      .rd_en   (exec),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   sjb_window #(
      .DEPTH (DEPTH),
      .IW    (IW)
   ) u_window (
      .slot_valid (slot_valid),
      .front      (front),
      .threshold  (threshold_ff),
      .ready_flag (ready_flag)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_push_status = status_ff;
   assign rsp_front_valid = flags.front_valid;
   assign rsp_front_data  = flags.front_valid ? rd_data : '0;
   assign rsp_ready_flag  = ready_flag;
   assign rsp_empty_flag  = flags.empty;

   a_exec_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      exec |=> rsp_valid_ff)
      else $error("executed beat produced no response");

   a_idle_takes_req: assert property (@(posedge clock) disable iff (reset)
      !req_valid_ff |-> req_ready)
      else $error("empty input register refused a beat");

   a_stall_holds_req: assert property (@(posedge clock) disable iff (reset)
      req_valid_ff && !exec |=> req_valid_ff && $stable(req_seq_ff))
      else $error("stalled request lost");

endmodule

[hdl/sjb_store.sv]
// ----------------------------------------------------------------------------
// Sequence jitter buffer entry store
// Slot data memory with a registered read of the front slot and a bypass
// of a write to the same slot in the same cycle.
// ----------------------------------------------------------------------------
module sjb_store #(
   parameter int DEPTH      = 32,
   parameter int DATA_WIDTH = 32,
   parameter int IW         = $clog2(DEPTH)
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [IW-1:0]         wr_addr,
   input  logic [DATA_WIDTH-1:0] wr_data,
   input  logic                  rd_en,
   input  logic [IW-1:0]         rd_addr,
   output logic [DATA_WIDTH-1:0] rd_data
);
   import sjb_pkg::*;

   logic [DATA_WIDTH-1:0] mem [DEPTH];
   logic [DATA_WIDTH-1:0] rd_ff;
   logic [DATA_WIDTH-1:0] byp_data_ff;
   logic                  byp_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff       <= mem[rd_addr];
         byp_ff      <= wr_en && (wr_addr == rd_addr);
         byp_data_ff <= wr_data;
      end
   end

   assign rd_data = byp_ff ? byp_data_ff : rd_ff;

endmodule

[hdl/sjb_window.sv]
// ----------------------------------------------------------------------------
// Sequence jitter buffer ready window
// Checks that the threshold-long run of slots starting at the front is full.
// ----------------------------------------------------------------------------
module sjb_window #(
   parameter int DEPTH = 32,
   parameter int IW    = $clog2(DEPTH)
) (
   input  logic [DEPTH-1:0]         slot_valid,
   input  logic [IW-1:0]            front,
   input  logic [sjb_pkg::THR_W-1:0] threshold,
   output logic                     ready_flag
);
   import sjb_pkg::*;

   localparam int CW = (IW + 1 > THR_W) ? IW + 1 : THR_W;

   logic [CW-1:0]    need;
   logic [DEPTH-1:0] in_window;

   always_comb begin
      logic [CW-1:0] pos;
      logic [CW-1:0] frt;
      logic [CW-1:0] span;
      frt = CW'(front);
      if (CW'(threshold) > CW'(DEPTH)) begin
         need = CW'(DEPTH);
      end else begin
         need = CW'(threshold);
      end
      for (int j = 0; j < DEPTH; j++) begin
         pos = CW'(j);
         if (pos >= frt) begin
            span = pos - frt;
         end else begin
            span = pos + CW'(DEPTH) - frt;
         end
         in_window[j] = (span < need);
      end
   end

   assign ready_flag = &(slot_valid | ~in_window);

endmodule

[hdl/sjb_ctrl.sv]
// ----------------------------------------------------------------------------
// Sequence jitter buffer control
// Base sequence, front pointer, slot valid bits and entry count; decides
// push status and drives the store write and front read.
// ----------------------------------------------------------------------------
module sjb_ctrl #(
   parameter int DEPTH = 32,
   parameter int IW    = $clog2(DEPTH)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          exec,
   input  logic                          op,
   input  logic [sjb_pkg::SEQ_W-1:0]     seq,
   output sjb_pkg::push_status_type      status,
   output logic                          wr_en,
   output logic [IW-1:0]                 wr_addr,
   output logic [IW-1:0]                 rd_addr,
   output logic [DEPTH-1:0]              slot_valid,
   output logic [IW-1:0]                 front,
   output sjb_pkg::flags_type            flags
);
   import sjb_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [DEPTH-1:0] valid_ff, valid_in;
   logic [SEQ_W-1:0] base_ff, base_in;
   logic [IW-1:0]    front_ff, front_in;
   logic [CNT_W-1:0] count_ff, count_in;

   logic             restart;
   logic             late;
   logic             early;
   logic [SEQ_W-1:0] base_eff;
   logic [SEQ_W-1:0] offset;
   logic [IW:0]      sum;
   logic [IW-1:0]    pos;

   always_comb begin
      restart  = (count_ff == '0) && (seq != base_ff);
      base_eff = restart ? seq : base_ff;
      late     = seq < base_ff;
      early    = {1'b0, seq} >= ({1'b0, base_ff} + (SEQ_W+1)'(DEPTH));
      offset   = seq - base_eff;
      sum      = {1'b0, offset[IW-1:0]} + {1'b0, front_ff};
      if (sum >= (IW+1)'(DEPTH)) begin
         pos = IW'(sum - (IW+1)'(DEPTH));
      end else begin
         pos = sum[IW-1:0];
      end
   end

   always_comb begin
      valid_in = valid_ff;
      base_in  = base_ff;
      front_in = front_ff;
      count_in = count_ff;
      status   = PUSH_NONE;
      wr_en    = 1'b0;
      if (exec) begin
         if (op == REQ_PUSH) begin
            base_in = base_eff;
            priority if (!restart && late) begin
               status = PUSH_LATE;
            end else if (!restart && early) begin
               status = PUSH_EARLY;
            end else if (valid_ff[pos]) begin
               status = PUSH_DUP;
            end else begin
               status        = PUSH_OK;
               valid_in[pos] = 1'b1;
               count_in      = count_ff + CNT_W'(1);
               wr_en         = 1'b1;
            end
         end else begin
            if (valid_ff[front_ff]) begin
               valid_in[front_ff] = 1'b0;
               count_in           = count_ff - CNT_W'(1);
            end
            base_in = base_ff + SEQ_W'(1);
            if (front_ff == IW'(DEPTH - 1)) begin
               front_in = '0;
            end else begin
               front_in = front_ff + IW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         base_ff  <= '0;
         front_ff <= '0;
         count_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         base_ff  <= base_in;
         front_ff <= front_in;
         count_ff <= count_in;
      end
   end

   assign wr_addr           = pos;
   assign rd_addr           = front_in;
   assign slot_valid        = valid_ff;
   assign front             = front_ff;
   assign flags.front_valid = valid_ff[front_ff];
   assign flags.empty       = (count_ff == '0);

   a_count_matches_valid: assert property (@(posedge clock) disable iff (reset)
      count_ff == CNT_W'($countones(valid_ff)))
      else $error("entry count out of step with slot valid bits");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count above depth");

   a_pop_advances: assert property (@(posedge clock) disable iff (reset)
      exec && (op == REQ_POP) |=> base_ff == $past(base_ff) + SEQ_W'(1))
      else $error("pop did not advance base sequence");

endmodule

[bench/tb_sequence_jitter_buffer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sequence jitter buffer testbench
// Sends push and pop beats with random gaps on both channels and predicts
// every response beat from a local copy of the ring, base and threshold.
// The run covers restarts, late, early and duplicate pushes, pops of an empty
// front, 16-bit base wrap and a range of ready thresholds.
// ----------------------------------------------------------------------------
module tb_sequence_jitter_buffer;
   import sjb_pkg::*;

   localparam int DEPTH       = DEF_DEPTH;
   localparam int DATA_W      = DEF_DATA_W;
   localparam int IDX_W       = $clog2(DEPTH);
   localparam int STALL_LIMIT = 4000;
   localparam int HOLD_CYCLES = 300;
   localparam int HOLD_EVERY  = 700;
   localparam int PHASE_ITEMS = 205;
   localparam int PHASES      = 9;

   typedef struct {
      logic              kind;
      logic [SEQ_W-1:0]  seq;
      logic [DATA_W-1:0] data;
   } request_type;

   typedef struct {
      push_status_type   status;
      logic              front_valid;
      logic [DATA_W-1:0] front_data;
      logic              ready;
      logic              empty;
   } buffer_view_type;

   class reorder_tracker_type;
      logic [THR_W-1:0]  threshold;
      logic              slot_full [DEPTH];
      logic [DATA_W-1:0] slot_word [DEPTH];
      logic [SEQ_W-1:0]  base;
      logic [IDX_W-1:0]  front;
      int unsigned       count;
      buffer_view_type   due [$];
      int                mismatches;
      int                requests;
      int                responses;

      function new();
         threshold  = '0;
         base       = '0;
         front      = '0;
         count      = 0;
         mismatches = 0;
         requests   = 0;
         responses  = 0;
         foreach (slot_full[i]) begin
            slot_full[i] = 1'b0;
            slot_word[i] = '0;
         end
      endfunction

      function push_status_type store_entry(logic [SEQ_W-1:0] seq, logic [DATA_W-1:0] word);
         logic [IDX_W-1:0] pos;
         if (count == 0 && seq != base) begin
            base = seq;
         end else begin
            if (seq < base) return PUSH_LATE;
            if (int'(seq) >= int'(base) + DEPTH) return PUSH_EARLY;
         end
         pos = IDX_W'(seq - base) + front;
         if (slot_full[pos]) return PUSH_DUP;
         slot_full[pos] = 1'b1;
         slot_word[pos] = word;
         count++;
         return PUSH_OK;
      endfunction

      function void release_front();
         if (slot_full[front]) begin
            slot_full[front] = 1'b0;
            count--;
         end
         base  = base + 1'b1;
         front = front + 1'b1;
      endfunction

      function logic window_full();
         int need;
         need = (threshold > DEPTH) ? DEPTH : threshold;
         for (int n = 0; n < need; n++) begin
            if (!slot_full[IDX_W'(front + n)]) return 1'b0;
         end
         return 1'b1;
      endfunction

      function void note_request(request_type rq);
         buffer_view_type v;
         if (rq.kind == REQ_PUSH) begin
            v.status = store_entry(rq.seq, rq.data);
         end else begin
            release_front();
            v.status = PUSH_NONE;
         end
         v.front_valid = slot_full[front];
         v.front_data  = slot_full[front] ? slot_word[front] : '0;
         v.ready       = window_full();
         v.empty       = (count == 0);
         due.push_back(v);
         requests++;
      endfunction

      task report(string what);
         mismatches++;
         $display("MISMATCH at %0t: %s", $time, what);
      endtask

      task check_response(buffer_view_type got);
         buffer_view_type want;
         responses++;
         if (due.size() == 0) begin
            report("response beat with nothing pending");
            return;
         end
         want = due.pop_front();
         if (got.status !== want.status)
            report($sformatf("push_status got %0d want %0d", got.status, want.status));
         if (got.front_valid !== want.front_valid)
            report($sformatf("front_valid got %b want %b", got.front_valid, want.front_valid));
         if (got.front_data !== want.front_data)
            report($sformatf("front_data got %h want %h", got.front_data, want.front_data));
         if (got.ready !== want.ready)
            report($sformatf("ready_flag got %b want %b", got.ready, want.ready));
         if (got.empty !== want.empty)
            report($sformatf("empty_flag got %b want %b", got.empty, want.empty));
      endtask
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic              req_type = REQ_PUSH;
   logic [SEQ_W-1:0]  req_seq_number = '0;
   logic [DATA_W-1:0] req_payload = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [STATUS_W-1:0] rsp_push_status;
   logic              rsp_front_valid;
   logic [DATA_W-1:0] rsp_front_data;
   logic              rsp_ready_flag;
   logic              rsp_empty_flag;
   logic              csr_wr_en = 1'b0;
   logic [THR_W-1:0]  csr_wr_data = '0;

   reorder_tracker_type tracker;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int settings_used = 0;
   int idle_cycles = 0;

   always #6 clock = ~clock;

   sequence_jitter_buffer #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_W)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_seq_number  (req_seq_number),
      .req_payload     (req_payload),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_push_status (rsp_push_status),
      .rsp_front_valid (rsp_front_valid),
      .rsp_front_data  (rsp_front_data),
      .rsp_ready_flag  (rsp_ready_flag),
      .rsp_empty_flag  (rsp_empty_flag),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   task send_beat(request_type rq);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_type       <= rq.kind;
      req_seq_number <= rq.seq;
      req_payload    <= rq.data;
      do @(posedge clock); while (!req_ready);
      tracker.note_request(rq);
   endtask

   task drain();
      req_valid <= 1'b0;
      while (tracker.due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task write_threshold(logic [THR_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      tracker.threshold = value;
      settings_used++;
   endtask

   // push base .. base+DEPTH-1 in order so the whole window fills
   task fill_window();
      request_type rq;
      logic [SEQ_W-1:0] start;
      start = tracker.base;
      for (int k = 0; k < DEPTH; k++) begin
         rq.kind = REQ_PUSH;
         rq.seq  = start + SEQ_W'(k);
         rq.data = $urandom;
         send_beat(rq);
      end
   endtask

   function request_type make_request(int pop_pct);
      request_type rq;
      int pick;
      rq.seq  = SEQ_W'($urandom);
      rq.data = $urandom;
      if ($urandom_range(0, 99) < pop_pct) begin
         rq.kind = REQ_POP;
         return rq;
      end
      rq.kind = REQ_PUSH;
      pick = $urandom_range(0, 99);
      if (pick < 80)
         rq.seq = tracker.base + SEQ_W'($urandom_range(0, $urandom_range(0, DEPTH - 1)));
      else if (pick < 87)
         rq.seq = tracker.base - SEQ_W'($urandom_range(1, 40));
      else if (pick < 94)
         rq.seq = tracker.base + SEQ_W'($urandom_range(DEPTH, DEPTH + 300));
      else if (pick < 97)
         rq.seq = '1 - SEQ_W'($urandom_range(0, 7));
      return rq;
   endfunction

   always @(posedge clock) begin
      buffer_view_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.status      = push_status_type'(rsp_push_status);
         got.front_valid = rsp_front_valid;
         got.front_data  = rsp_front_data;
         got.ready       = rsp_ready_flag;
         got.empty       = rsp_empty_flag;
         tracker.check_response(got);
      end
   end

   // hold off the response side for a long stretch every so often
   initial begin : receiver
      int seen;
      int held;
      logic hold_now;
      seen = 0;
      forever begin
         @(posedge clock);
         hold_now = 1'b0;
         if (!reset && rsp_valid && rsp_ready) begin
            seen++;
            hold_now = (seen % HOLD_EVERY == 0);
         end
         if (hold_now) begin
            rsp_ready <= 1'b0;
            held = 0;
            while (held < HOLD_CYCLES) begin
               @(posedge clock);
               held++;
            end
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("timeout: no beat moved for %0d cycles", STALL_LIMIT);
         $display("sequence_jitter_buffer verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      request_type intro [20];
      int thr_plan [PHASES];
      int pop_pct;
      intro = '{
         '{REQ_POP,  16'h0000, 32'h0000_0000},
         '{REQ_PUSH, 16'h0000, 32'h0000_0000},
         '{REQ_PUSH, 16'h0000, 32'h1234_5678},
         '{REQ_PUSH, 16'h0001, 32'hFFFF_FFFF},
         '{REQ_PUSH, 16'h0020, 32'h0000_0000},
         '{REQ_PUSH, 16'hFFFF, 32'h0000_0000},
         '{REQ_POP,  16'hFFFF, 32'hFFFF_FFFF},
         '{REQ_PUSH, 16'h0000, 32'h0F0F_0F0F},
         '{REQ_POP,  16'h0000, 32'h0000_0000},
         '{REQ_PUSH, 16'hFFFE, 32'hA5A5_A5A5},
         '{REQ_PUSH, 16'hFFFF, 32'h5A5A_5A5A},
         '{REQ_PUSH, 16'h0000, 32'h0000_0001},
         '{REQ_POP,  16'h0000, 32'h0000_0000},
         '{REQ_POP,  16'h0000, 32'h0000_0000},
         '{REQ_PUSH, 16'h0000, 32'hC3C3_C3C3},
         '{REQ_PUSH, 16'h001F, 32'hFFFF_FFFF},
         '{REQ_PUSH, 16'h001F, 32'h0000_0000},
         '{REQ_POP,  16'h0000, 32'h0000_0000},
         '{REQ_POP,  16'h0000, 32'h0000_0000},
         '{REQ_PUSH, 16'h0000, 32'h8000_0000}
      };
      thr_plan = '{0, 32, 63, 1, 5, 31, 16, 2, 33};
      tracker = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_threshold(THR_W'(2));
      foreach (intro[i]) send_beat(intro[i]);
      drain();
      for (int p = 0; p < PHASES; p++) begin
         send_idle_pct = (p < 3) ? 22 : ((p < 6) ? 71 : 0);
         recv_idle_pct = (p < 3) ? 71 : ((p < 6) ? 22 : 0);
         write_threshold(THR_W'(thr_plan[p]));
         fill_window();
         pop_pct = 40;
         for (int n = 0; n < PHASE_ITEMS - DEPTH; n++) begin
            if (n % 50 == 0) begin
               case ($urandom_range(0, 2))
                  0: pop_pct = 15;
                  1: pop_pct = 40;
                  default: pop_pct = 65;
               endcase
            end
            send_beat(make_request(pop_pct));
         end
         drain();
      end
      $display("run covered %0d requests and %0d responses under %0d threshold settings",
               tracker.requests, tracker.responses, settings_used);
      $display("with restarts, late, early, duplicate pushes, base wrap and long output stalls");
      if (tracker.mismatches == 0) begin
         $display("sequence_jitter_buffer verification clean");
      end else begin
         $display("sequence_jitter_buffer verification failed");
      end
      $finish;
   end

endmodule

[files.f]
hdl/sjb_pkg.sv
hdl/sjb_store.sv
hdl/sjb_window.sv
hdl/sjb_ctrl.sv
hdl/sequence_jitter_buffer.sv
bench/tb_sequence_jitter_buffer.sv
